/* rtl/lge_pkg.sv */
// Shared types and constants of the life grid generation engine.
`timescale 1ns / 1ps
`default_nettype none

package lge_pkg;

  localparam int FUNC_W     = 2;
  localparam int ROW_IDX_W  = 6;
  localparam int COL_IDX_W  = 6;
  localparam int SIZE_W     = 7;
  localparam int GEN_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int NBR_W      = 4;

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

  typedef struct packed {
    logic capture;
    logic cell_rd;
    logic cell_op;
    logic g_up;
    logic g_mid;
    logic g_dn;
    logic g_load;
    logic g_row;
    logic g_end;
  } dp_cmd_t;

  typedef struct packed {
    logic bad;
    logic limit_zero;
    logic last_row;
    logic changed;
    logic gen_last;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/lge_controller.sv */
// Sequencer that steps cell operations and generation runs through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module lge_controller (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [lge_pkg::FUNC_W-1:0] func,
  input  wire lge_pkg::dp_status_t       st,
  output lge_pkg::dp_cmd_t               cmd,
  output logic                           busy,
  output logic                           done
);
  import lge_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CELL_RD,
    S_CELL_OP,
    S_RUN_CHK,
    S_G_UP,
    S_G_MID,
    S_G_DN,
    S_G_LOAD,
    S_G_ROW,
    S_G_END,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start && !busy) begin
          cmd.capture = 1'b1;
          unique case (func) inside
            FUNC_WRITE, FUNC_READ: state_next = S_CELL_RD;
            FUNC_RUN:              state_next = S_RUN_CHK;
            default:               state_next = S_DONE;
          endcase
        end
      end
      S_CELL_RD: begin
        cmd.cell_rd = 1'b1;
        state_next  = st.bad ? S_DONE : S_CELL_OP;
      end
      S_CELL_OP: begin
        cmd.cell_op = 1'b1;
        state_next  = S_DONE;
      end
      S_RUN_CHK: begin
        state_next = st.limit_zero ? S_DONE : S_G_UP;
      end
      S_G_UP: begin
        cmd.g_up   = 1'b1;
        state_next = S_G_MID;
      end
      S_G_MID: begin
        cmd.g_mid  = 1'b1;
        state_next = S_G_DN;
      end
      S_G_DN: begin
        cmd.g_dn   = 1'b1;
        state_next = S_G_LOAD;
      end
      S_G_LOAD: begin
        cmd.g_load = 1'b1;
        state_next = S_G_ROW;
      end
      S_G_ROW: begin
        cmd.g_row = 1'b1;
        if (st.last_row) begin
          state_next = S_G_END;
        end
      end
      S_G_END: begin
        cmd.g_end = 1'b1;
        if (!st.changed || st.gen_last) begin
          state_next = S_DONE;
        end else begin
          state_next = S_G_UP;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= (state_next == S_DONE);
    end
  end

endmodule

`default_nettype wire

/* rtl/lge_datapath.sv */
// Grid row memory, three-row window, next-row logic, counters and result registers.
`timescale 1ns / 1ps
`default_nettype none

module lge_datapath #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lge_pkg::dp_cmd_t              cmd,
  output lge_pkg::dp_status_t                st,
  input  wire logic [lge_pkg::FUNC_W-1:0]     func,
  input  wire logic [lge_pkg::ROW_IDX_W-1:0]  row_index,
  input  wire logic [lge_pkg::COL_IDX_W-1:0]  col_index,
  input  wire logic                          cell_value,
  input  wire logic                          cfg_write,
  input  wire logic [lge_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lge_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                               cell_out,
  output logic [lge_pkg::GEN_W-1:0]           generations_applied,
  output logic                               stable,
  output logic                               bad_coordinate
);
  import lge_pkg::*;

  localparam int RA   = $clog2(MAX_ROWS);
  localparam int CA   = $clog2(MAX_COLS);
  localparam int RN   = $clog2(MAX_ROWS + 1);
  localparam int CN   = $clog2(MAX_COLS + 1);
  localparam int RN1  = RN + 1;
  localparam int RC_W = ((RN > ROW_IDX_W) ? RN : ROW_IDX_W) + 1;
  localparam int CC_W = ((CN > COL_IDX_W) ? CN : COL_IDX_W) + 1;
  localparam int GEN_W1 = GEN_W + 1;

  logic [SIZE_W-1:0]    rows_q;
  logic [SIZE_W-1:0]    cols_q;
  logic [GEN_W-1:0]     limit_q;
  logic [RN-1:0]        nr;
  logic [CN-1:0]        nc;
  logic [CA-1:0]        last_col;

  logic [FUNC_W-1:0]    func_q;
  logic [ROW_IDX_W-1:0] row_q;
  logic [COL_IDX_W-1:0] col_q;
  logic                 val_q;
  logic                 bad;

  logic [MAX_COLS-1:0]  mem [MAX_ROWS];
  logic [MAX_ROWS-1:0]  rvalid;
  logic [MAX_COLS-1:0]  rd_q;
  logic                 rd_vq;
  logic [MAX_COLS-1:0]  rd_row;
  logic                 rd_en;
  logic [RA-1:0]        rd_addr;
  logic                 wr_en;
  logic [RA-1:0]        wr_addr;
  logic [MAX_COLS-1:0]  wr_data;
  logic [MAX_COLS-1:0]  cell_row;

  logic [MAX_COLS-1:0]  up_q;
  logic [MAX_COLS-1:0]  mid_q;
  logic [MAX_COLS-1:0]  dn_q;
  logic [MAX_COLS-1:0]  row0_q;
  logic [MAX_COLS-1:0]  up_l;
  logic [MAX_COLS-1:0]  up_r;
  logic [MAX_COLS-1:0]  mid_l;
  logic [MAX_COLS-1:0]  mid_r;
  logic [MAX_COLS-1:0]  dn_l;
  logic [MAX_COLS-1:0]  dn_r;
  logic [MAX_COLS-1:0]  new_row;
  logic                 row_changed;

  logic [RA-1:0]        rcnt;
  logic [RN1-1:0]       ahead2;
  logic [RN1-1:0]       ahead3;
  logic                 chg_q;

  logic                 cell_q;
  logic [GEN_W-1:0]     applied_q;
  logic                 stable_q;
  logic                 bad_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_q  <= SIZE_RESET;
      cols_q  <= SIZE_RESET;
      limit_q <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ROWS:  rows_q  <= cfg_data[SIZE_W-1:0];
        CFG_COLS:  cols_q  <= cfg_data[SIZE_W-1:0];
        CFG_LIMIT: limit_q <= cfg_data[GEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A zero size counts as one and a size above the maximum saturates.
  always_comb begin
    if (rows_q == '0) begin
      nr = RN'(1);
    end else if (32'(rows_q) > MAX_ROWS) begin
      nr = RN'(MAX_ROWS);
    end else begin
      nr = RN'(rows_q);
    end
    if (cols_q == '0) begin
      nc = CN'(1);
    end else if (32'(cols_q) > MAX_COLS) begin
      nc = CN'(MAX_COLS);
    end else begin
      nc = CN'(cols_q);
    end
  end

  assign last_col = CA'(nc - CN'(1));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= func;
      row_q  <= row_index;
      col_q  <= col_index;
      val_q  <= cell_value;
    end
  end

  assign bad = (RC_W'(row_q) >= RC_W'(nr)) || (CC_W'(col_q) >= CC_W'(nc));

  assign ahead2 = RN1'(rcnt) + RN1'(2);
  assign ahead3 = RN1'(rcnt) + RN1'(3);

  always_comb begin
    cell_row = rd_row;
    cell_row[CA'(col_q)] = val_q;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = new_row;
    if (cmd.cell_rd) begin
      rd_en   = !bad;
      rd_addr = RA'(row_q);
    end
    if (cmd.cell_op && (func_q == FUNC_WRITE)) begin
      wr_en   = 1'b1;
      wr_addr = RA'(row_q);
      wr_data = cell_row;
    end
    if (cmd.g_up) begin
      rd_en   = 1'b1;
      rd_addr = RA'(nr - RN'(1));
    end
    if (cmd.g_mid) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end
    if (cmd.g_dn) begin
      rd_en   = 1'b1;
      rd_addr = (nr == RN'(1)) ? '0 : RA'(1);
    end
    if (cmd.g_load) begin
      rd_en   = (nr > RN'(2));
      rd_addr = RA'(2);
    end
    if (cmd.g_row) begin
      rd_en   = (ahead3 < RN1'(nr));
      rd_addr = RA'(ahead3);
      wr_en   = 1'b1;
      wr_addr = rcnt;
      wr_data = new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Rows never written since reset read as all dead.
  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= '0;
      rd_vq  <= 1'b0;
    end else begin
      if (wr_en) begin
        rvalid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vq <= rvalid[rd_addr];
      end
    end
  end

  assign rd_row = rd_vq ? rd_q : '0;

  always_comb begin
    logic [NBR_W-1:0] nbr;
    logic             wrap_r;
    nbr = '0;
    wrap_r = 1'b0;
    for (int c = 0; c < MAX_COLS; c++) begin
      wrap_r   = (CN'(c) == (nc - CN'(1)));
      up_l[c]  = (c == 0) ? up_q[last_col]  : up_q[(c + MAX_COLS - 1) % MAX_COLS];
      mid_l[c] = (c == 0) ? mid_q[last_col] : mid_q[(c + MAX_COLS - 1) % MAX_COLS];
      dn_l[c]  = (c == 0) ? dn_q[last_col]  : dn_q[(c + MAX_COLS - 1) % MAX_COLS];
      up_r[c]  = wrap_r ? up_q[0]  : up_q[(c + 1) % MAX_COLS];
      mid_r[c] = wrap_r ? mid_q[0] : mid_q[(c + 1) % MAX_COLS];
      dn_r[c]  = wrap_r ? dn_q[0]  : dn_q[(c + 1) % MAX_COLS];
      nbr = NBR_W'(up_l[c]) + NBR_W'(up_q[c]) + NBR_W'(up_r[c])
          + NBR_W'(mid_l[c]) + NBR_W'(mid_r[c])
          + NBR_W'(dn_l[c]) + NBR_W'(dn_q[c]) + NBR_W'(dn_r[c]);
      if (CN'(c) < nc) begin
        new_row[c] = (nbr == BIRTH_COUNT) || (mid_q[c] && (nbr == SURVIVE_COUNT));
      end else begin
        new_row[c] = mid_q[c];
      end
    end
  end

  assign row_changed = |(new_row ^ mid_q);

  always_ff @(posedge clk) begin
    if (cmd.g_mid) begin
      up_q <= rd_row;
    end
    if (cmd.g_dn) begin
      mid_q  <= rd_row;
      row0_q <= rd_row;
    end
    if (cmd.g_load) begin
      dn_q <= rd_row;
    end
    if (cmd.g_row) begin
      up_q  <= mid_q;
      mid_q <= dn_q;
      dn_q  <= (ahead2 < RN1'(nr)) ? rd_row : row0_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rcnt      <= '0;
      chg_q     <= 1'b0;
      cell_q    <= 1'b0;
      applied_q <= '0;
      stable_q  <= 1'b0;
      bad_q     <= 1'b0;
    end else begin
      if (cmd.capture) begin
        cell_q    <= 1'b0;
        applied_q <= '0;
        stable_q  <= 1'b0;
        bad_q     <= 1'b0;
      end
      if (cmd.cell_rd && bad) begin
        bad_q <= 1'b1;
      end
      if (cmd.cell_op && (func_q == FUNC_READ)) begin
        cell_q <= rd_row[CA'(col_q)];
      end
      if (cmd.g_up) begin
        rcnt  <= '0;
        chg_q <= 1'b0;
      end
      if (cmd.g_row) begin
        rcnt  <= rcnt + RA'(1);
        chg_q <= chg_q | row_changed;
      end
      if (cmd.g_end) begin
        if (chg_q) begin
          applied_q <= applied_q + GEN_W'(1);
        end else begin
          stable_q <= 1'b1;
        end
      end
    end
  end

  assign st.bad        = bad;
  assign st.limit_zero = (limit_q == '0);
  assign st.last_row   = ((RN'(rcnt) + RN'(1)) == nr);
  assign st.changed    = chg_q;
  assign st.gen_last   = ((GEN_W1'(applied_q) + GEN_W1'(1)) == GEN_W1'(limit_q));

  assign cell_out            = cell_q;
  assign generations_applied = applied_q;
  assign stable              = stable_q;
  assign bad_coordinate      = bad_q;

endmodule

`default_nettype wire

/* rtl/life_grid_generation_engine.sv */
// Top level of the toroidal B3/S23 life grid engine.
//
// A command is taken at a rising edge where start is high and busy is low.
// The func port picks the operation: write one cell, read one cell, or run
// generations over the rows and columns in use, with wraparound at both.
// Each command ends in exactly one result transfer: done is high for one
// cycle and the result ports hold the values; the receiver cannot stall it.
// Cell reads and writes pass through a row read and a cell operation before
// done; a bad coordinate skips the cell operation, and operation code 3 and a
// zero generation limit go straight to done. A generation loads the last row,
// row zero and row one into the window, then steps through the rows. The row
// memory delivers one row per cycle and one new row is computed per cycle.
// The run stops early after the first generation that changes nothing.
// busy stays high until the cycle after done; the next command follows then.
// Configuration writes take effect at the edge where cfg_write is high. The user
// must make them only while busy is low; the block does not enforce it. Reset
// clears the per-row valid bits, so the whole grid reads as dead at once with
// no clearing pass, and restores 64 rows, 64 columns and generation limit zero.
`timescale 1ns / 1ps
`default_nettype none

module life_grid_generation_engine #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [lge_pkg::FUNC_W-1:0]     func,
  input  wire logic [lge_pkg::ROW_IDX_W-1:0]  row_index,
  input  wire logic [lge_pkg::COL_IDX_W-1:0]  col_index,
  input  wire logic                          cell_value,
  output logic                               done,
  output logic                               cell_out,
  output logic [lge_pkg::GEN_W-1:0]           generations_applied,
  output logic                               stable,
  output logic                               bad_coordinate,
  input  wire logic                          cfg_write,
  input  wire logic [lge_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lge_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lge_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_st;

  lge_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .st    (dp_st),
    .cmd   (dp_cmd),
    .busy  (busy),
    .done  (done)
  );

  lge_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (dp_cmd),
    .st                  (dp_st),
    .func                (func),
    .row_index           (row_index),
    .col_index           (col_index),
    .cell_value          (cell_value),
    .cfg_write           (cfg_write),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .cell_out            (cell_out),
    .generations_applied (generations_applied),
    .stable              (stable),
    .bad_coordinate      (bad_coordinate)
  );

`ifndef SYNTHESIS
  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("Result transfer without a command in progress.");

  a_busy_ends_after_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(done))
    else $error("Command ended without a result transfer.");

  a_stable_from_run_end: assert property (@(posedge clk) disable iff (rst)
    (done && stable) |-> $past(dp_cmd.g_end))
    else $error("Stable flag reported without a finished generation.");

  a_bad_only_cell_ops: assert property (@(posedge clk) disable iff (rst)
    done |-> !(bad_coordinate && (generations_applied != '0)))
    else $error("Bad coordinate reported together with applied generations.");
`endif

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench of the life grid generation engine, with its own grid predictor.
`timescale 1ns / 1ps

module tb_top;
  import lge_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_IDLE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int GRID_DIM = 64;
  localparam int RANDOM_ITEMS = 1700;

  typedef struct packed {
    logic cell_bit;
    logic [GEN_W-1:0] gens;
    logic stable;
    logic bad;
  } life_result_t;

  class life_scoreboard;
    bit cells[GRID_DIM][GRID_DIM];
    bit [SIZE_W-1:0] rows_reg;
    bit [SIZE_W-1:0] cols_reg;
    bit [GEN_W-1:0] limit_reg;
    life_result_t expected_q[$];
    int errors;

    function new();
      rows_reg = SIZE_RESET;
      cols_reg = SIZE_RESET;
      limit_reg = '0;
      errors = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ROWS: rows_reg = data[SIZE_W-1:0];
        CFG_COLS: cols_reg = data[SIZE_W-1:0];
        CFG_LIMIT: limit_reg = data[GEN_W-1:0];
        default: ;
      endcase
    endfunction

    function int clamp_size(bit [SIZE_W-1:0] v);
      if (v == 0) return 1;
      if (v > GRID_DIM) return GRID_DIM;
      return v;
    endfunction

    // Neighbors wrap at the sizes in use; with tiny sizes a cell may be counted several times.
    function int live_around(int r, int c, int nr, int nc);
      int sum;
      int rr;
      int cc;
      sum = 0;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          if (dr != 0 || dc != 0) begin
            rr = (r + nr + dr) % nr;
            cc = (c + nc + dc) % nc;
            sum += cells[rr][cc];
          end
        end
      end
      return sum;
    endfunction

    function bit advance_generation(int nr, int nc);
      bit fresh[GRID_DIM][GRID_DIM];
      bit changed;
      int n;
      changed = 1'b0;
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          n = live_around(r, c, nr, nc);
          fresh[r][c] = (n == BIRTH_COUNT) || (cells[r][c] && n == SURVIVE_COUNT);
          if (fresh[r][c] != cells[r][c]) changed = 1'b1;
        end
      end
      if (changed) begin
        for (int r = 0; r < nr; r++) begin
          for (int c = 0; c < nc; c++) cells[r][c] = fresh[r][c];
        end
      end
      return changed;
    endfunction

    function void note_command(logic [FUNC_W-1:0] f, logic [ROW_IDX_W-1:0] row,
                               logic [COL_IDX_W-1:0] col, logic val);
      life_result_t res;
      int nr;
      int nc;
      res = '0;
      nr = clamp_size(rows_reg);
      nc = clamp_size(cols_reg);
      case (f)
        FUNC_WRITE, FUNC_READ: begin
          if (row >= nr || col >= nc) res.bad = 1'b1;
          else if (f == FUNC_WRITE) cells[row][col] = val;
          else res.cell_bit = cells[row][col];
        end
        FUNC_RUN: begin
          for (int g = 0; g < limit_reg; g++) begin
            if (!advance_generation(nr, nc)) begin
              res.stable = 1'b1;
              break;
            end
            res.gens++;
          end
        end
        default: ;
      endcase
      expected_q.push_back(res);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t ns: %s", $time, what);
      errors++;
    endtask

    task check_result(life_result_t got);
      life_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: cell %0d gens %0d %s %0d %s %0d",
                                  got.cell_bit, got.gens, "stable", got.stable,
                                  "bad", got.bad));
        return;
      end
      want = expected_q.pop_front();
      if (got.cell_bit !== want.cell_bit)
        report_mismatch($sformatf("cell_out %0b, want %0b", got.cell_bit, want.cell_bit));
      if (got.gens !== want.gens)
        report_mismatch($sformatf("generations_applied %0d, want %0d", got.gens, want.gens));
      if (got.stable !== want.stable)
        report_mismatch($sformatf("stable %0b, want %0b", got.stable, want.stable));
      if (got.bad !== want.bad)
        report_mismatch($sformatf("bad_coordinate %0b, want %0b", got.bad, want.bad));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [FUNC_W-1:0] func = FUNC_WRITE;
  logic [ROW_IDX_W-1:0] row_index = '0;
  logic [COL_IDX_W-1:0] col_index = '0;
  logic cell_value = 1'b0;
  logic done;
  logic cell_out;
  logic [GEN_W-1:0] generations_applied;
  logic stable;
  logic bad_coordinate;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ROWS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  life_scoreboard board = new();
  int gap_cap = 6;

  life_grid_generation_engine i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_result({cell_out, generations_applied, stable, bad_coordinate});
  end

  initial begin
    #200_000_000;
    $display("** life_grid_generation_engine: FAILED **");
    $finish;
  end

  task automatic send_command(logic [FUNC_W-1:0] f, logic [ROW_IDX_W-1:0] r,
                              logic [COL_IDX_W-1:0] c, logic v);
    int gap;
    gap = $urandom_range(0, gap_cap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    row_index <= r;
    col_index <= c;
    cell_value <= v;
    do @(posedge clk); while (busy);
    board.note_command(f, r, c, v);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (busy || board.expected_q.size() != 0);
  endtask

  // Leaves the write enable high so that back-to-back writes form one burst.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.set_register(idx, data);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] rows_d, logic [CFG_DATA_W-1:0] cols_d,
                           logic [CFG_DATA_W-1:0] limit_d);
    write_register(CFG_ROWS, rows_d);
    write_register(CFG_COLS, cols_d);
    write_register(CFG_LIMIT, limit_d);
    cfg_write <= 1'b0;
  endtask

  function automatic int pick_size(int typical_max);
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
      1: return $urandom_range(25, 64);
      default: return $urandom_range(1, typical_max);
    endcase
  endfunction

  initial begin
    int items;
    int n;
    int pick;
    int nr;
    int nc;
    int limit_val;
    bit spare_done;
    logic [ROW_IDX_W-1:0] r;
    logic [COL_IDX_W-1:0] c;

    items = 0;
    spare_done = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_command(FUNC_READ, 6'd63, 6'd63, 1'b0);
    send_command(FUNC_RUN, 6'd0, 6'd0, 1'b0);
    send_command(FUNC_IDLE, 6'd63, 6'd63, 1'b1);
    // A still-life block that straddles the wrap corner, and a tromino that turns into a block.
    send_command(FUNC_WRITE, 6'd0, 6'd0, 1'b1);
    send_command(FUNC_WRITE, 6'd0, 6'd63, 1'b1);
    send_command(FUNC_WRITE, 6'd63, 6'd0, 1'b1);
    send_command(FUNC_WRITE, 6'd63, 6'd63, 1'b1);
    send_command(FUNC_WRITE, 6'd20, 6'd20, 1'b1);
    send_command(FUNC_WRITE, 6'd20, 6'd21, 1'b1);
    send_command(FUNC_WRITE, 6'd21, 6'd20, 1'b1);
    settle();
    configure(16'h0040, 16'h0040, 16'hFFFF);
    send_command(FUNC_RUN, 6'd0, 6'd0, 1'b0);
    send_command(FUNC_READ, 6'd21, 6'd21, 1'b0);
    settle();
    configure(16'hFF80, 16'h0043, 16'h0003);
    send_command(FUNC_WRITE, 6'd1, 6'd0, 1'b1);
    send_command(FUNC_READ, 6'd0, 6'd63, 1'b0);
    send_command(FUNC_READ, 6'd5, 6'd2, 1'b0);
    send_command(FUNC_RUN, 6'd0, 6'd0, 1'b0);
    settle();
    configure(16'h0002, 16'h0001, 16'h0002);
    send_command(FUNC_WRITE, 6'd1, 6'd0, 1'b1);
    send_command(FUNC_RUN, 6'd0, 6'd0, 1'b0);
    send_command(FUNC_READ, 6'd1, 6'd0, 1'b0);
    settle();
    configure(16'h0040, 16'h0040, 16'h0004);
    send_command(FUNC_WRITE, 6'd40, 6'd30, 1'b1);
    send_command(FUNC_WRITE, 6'd40, 6'd31, 1'b1);
    send_command(FUNC_WRITE, 6'd40, 6'd32, 1'b1);
    send_command(FUNC_RUN, 6'd0, 6'd0, 1'b0);
    send_command(FUNC_READ, 6'd39, 6'd31, 1'b0);
    send_command(FUNC_WRITE, 6'd62, 6'd1, 1'b0);

    while (items < RANDOM_ITEMS) begin
      settle();
      if (!spare_done) begin
        write_register(CFG_SPARE, 16'hFFFF);
        spare_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        0: limit_val = 0;
        1: limit_val = $urandom_range(7, 20);
        default: limit_val = $urandom_range(1, 6);
      endcase
      configure({9'($urandom), 7'(pick_size(12))}, {9'($urandom), 7'(pick_size(40))},
                16'(limit_val));
      gap_cap = ($urandom_range(0, 3) == 0) ? 0 : 6;
      nr = board.clamp_size(board.rows_reg);
      nc = board.clamp_size(board.cols_reg);
      n = $urandom_range(20, 60);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        r = 6'($urandom_range(0, nr - 1));
        c = 6'($urandom_range(0, nc - 1));
        if (pick < 55) begin
          send_command(FUNC_WRITE, r, c, $urandom_range(0, 99) < 45);
        end else if (pick < 62) begin
          send_command(FUNC_WRITE, 6'($urandom), 6'($urandom), 1'($urandom));
        end else if (pick < 82) begin
          if ($urandom_range(0, 3) == 0) send_command(FUNC_READ, 6'($urandom), 6'($urandom),
                                                      1'($urandom));
          else send_command(FUNC_READ, r, c, 1'($urandom));
        end else if (pick < 95) begin
          send_command(FUNC_RUN, 6'($urandom), 6'($urandom), 1'($urandom));
        end else begin
          send_command(FUNC_IDLE, 6'($urandom), 6'($urandom), 1'($urandom));
          items--;
        end
        items++;
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("** life_grid_generation_engine: PASSED **");
    end else begin
      $display("** life_grid_generation_engine: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/lge_pkg.sv
rtl/lge_controller.sv
rtl/lge_datapath.sv
rtl/life_grid_generation_engine.sv
tb/tb_top.sv
